// ===== hdl/lrd_pkg.sv =====
// ============================================================================
// lrd_pkg: shared types and constants of the log record deframer
// Event codes, parser phases, limits and the compact result record that
// travels from the parser front end through the result queue to the output.
// ============================================================================
`default_nettype none

package lrd_pkg;

    // Widths fixed by the record format and the result fields.
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned PLIM_W     = 17;
    localparam int unsigned EVENT_W    = 3;
    localparam int unsigned REC_CNT_W  = 32;
    localparam int unsigned CFG_IDX_W  = 1;

    // Header layout: eight sequence bytes, type, operation, two length bytes.
    localparam logic [LEN_W-1:0] HDR_TYPE_POS = 16'd8;
    localparam logic [LEN_W-1:0] HDR_OP_POS   = 16'd9;
    localparam logic [LEN_W-1:0] HDR_LEN_POS  = 16'd10;
    localparam logic [LEN_W-1:0] HDR_LAST_POS = 16'd11;

    // Payload length field is four bytes; the top two must be zero to pass.
    localparam logic [LEN_W-1:0] PLEN_HI1_POS = 16'd1;
    localparam logic [LEN_W-1:0] PLEN_LAST_POS = 16'd3;

    // Effective ceiling on the payload limit register.
    localparam logic [PLIM_W-1:0] PLIM_CEIL = 17'd65536;

    // Reset values of the configuration registers.
    localparam logic [LEN_W-1:0]  KEY_LIMIT_RST     = 16'd256;
    localparam logic [PLIM_W-1:0] PAYLOAD_LIMIT_RST = 17'd4096;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LIMIT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 1'b1;

    // Result queue depth.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Event codes of a result.
    localparam logic [EVENT_W-1:0] EV_HEADER  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_KEY     = 3'd1;
    localparam logic [EVENT_W-1:0] EV_PLEN    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_PAYLOAD = 3'd3;
    localparam logic [EVENT_W-1:0] EV_ERROR   = 3'd4;
    localparam logic [EVENT_W-1:0] EV_END     = 3'd5;

    // Error codes.
    localparam logic ERR_KEY_LONG     = 1'b0;
    localparam logic ERR_PAYLOAD_LONG = 1'b1;

    // Parser phases, one-hot.
    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_KEY     = 5'b00010,
        PH_PLEN    = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_ERROR   = 5'b10000
    } t_phase;

    // Compact result record; flag is the error code or the end status.
    typedef struct packed {
        logic [EVENT_W-1:0]   ev;
        logic [BYTE_W-1:0]    rtype;
        logic [BYTE_W-1:0]    op;
        logic [LEN_W-1:0]     len;
        logic [BYTE_W-1:0]    data;
        logic                 done;
        logic                 flag;
        logic [REC_CNT_W-1:0] count;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/log_record_deframer.sv =====
// ============================================================================
// log_record_deframer: length-prefixed log record parser
// Parses a big-endian byte stream of log records and reports header, key
// bytes, payload length, payload bytes, errors and end of stream.
// ============================================================================
// Usage:
//   Input channel: drive i_kind and i_data_byte with push; a transaction is
//   taken at a clock edge where push is high and full is low. One byte or
//   end-of-stream item can be taken every cycle.
//   Result channel: while empty is low the oldest result is on the o_ ports;
//   it is taken at a clock edge where pop is high. Sequence bytes and partial
//   length bytes give no result.
//   Configuration: key limit (index 0) and payload limit (index 1) are
//   written through i_cfg_valid; o_cfg_ready is always high. Write only
//   while the block is idle.
//   A result reaches the o_ ports by a queue write at the edge that takes
//   its input transaction, then an output register load.
//   Throughput: one item per cycle while full is low.
//   A four-entry result queue plus the output register absorb receiver
//   stalls; full rises once they are all occupied.
//   Reset clears the parse state, empties the queue and the output register,
//   and loads the limits with 256 and 4096.
// ============================================================================
`default_nettype none

module log_record_deframer #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          i_kind,
    input  wire logic [lrd_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [lrd_pkg::EVENT_W-1:0]        o_event_res,
    output logic [lrd_pkg::BYTE_W-1:0]         o_record_type,
    output logic [lrd_pkg::BYTE_W-1:0]         o_operation,
    output logic [lrd_pkg::LEN_W-1:0]          o_key_length,
    output logic [lrd_pkg::LEN_W-1:0]          o_payload_length,
    output logic [lrd_pkg::BYTE_W-1:0]         o_data_out,
    output logic                               o_record_done,
    output logic                               o_error_code,
    output logic                               o_end_status,
    output logic [lrd_pkg::REC_CNT_W-1:0]      o_record_count,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lrd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lrd_pkg::PLIM_W-1:0]    i_cfg_data
);
    import lrd_pkg::*;

    logic [LEN_W-1:0]  r_key_limit;
    logic [PLIM_W-1:0] r_payload_limit;
    logic              w_accept;
    t_result           w_res;
    logic              w_res_valid;
    t_result           w_q_data;
    logic              w_q_empty;
    logic              w_q_rd;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_limit     <= KEY_LIMIT_RST;
            r_payload_limit <= PAYLOAD_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_LIMIT:     r_key_limit     <= i_cfg_data[LEN_W-1:0];
                CFG_PAYLOAD_LIMIT: r_payload_limit <= i_cfg_data;
                default: begin
                    r_key_limit <= r_key_limit;
                end
            endcase
        end
    end

    assign w_accept = push && !full;

    // Parser front end.
    lrd_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_kind          (i_kind),
        .i_data_byte     (i_data_byte),
        .i_key_limit     (r_key_limit),
        .i_payload_limit (r_payload_limit),
        .o_res           (w_res),
        .o_res_valid     (w_res_valid)
    );

    // Result queue.
    lrd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_res_valid),
        .i_wr_data (w_res),
        .i_rd      (w_q_rd),
        .o_rd_data (w_q_data),
        .o_full    (full),
        .o_empty   (w_q_empty)
    );

    // Output stage.
    lrd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_data         (w_q_data),
        .i_q_empty        (w_q_empty),
        .o_q_rd           (w_q_rd),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_event_res      (o_event_res),
        .o_record_type    (o_record_type),
        .o_operation      (o_operation),
        .o_key_length     (o_key_length),
        .o_payload_length (o_payload_length),
        .o_data_out       (o_data_out),
        .o_record_done    (o_record_done),
        .o_error_code     (o_error_code),
        .o_end_status     (o_end_status),
        .o_record_count   (o_record_count)
    );

endmodule

`default_nettype wire

// ===== hdl/lrd_front.sv =====
// ============================================================================
// lrd_front: record parser front end
// Takes one stream item per accepted transaction, advances the parse state
// and produces at most one compact result record for the result queue.
// ============================================================================
`default_nettype none

module lrd_front #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic                          i_kind,
    input  wire logic [lrd_pkg::BYTE_W-1:0]    i_data_byte,
    input  wire logic [lrd_pkg::LEN_W-1:0]     i_key_limit,
    input  wire logic [lrd_pkg::PLIM_W-1:0]    i_payload_limit,
    output lrd_pkg::t_result                   o_res,
    output logic                               o_res_valid
);
    import lrd_pkg::*;

    t_phase                r_phase, n_phase;
    logic [LEN_W-1:0]      r_cnt, n_cnt;
    logic [BYTE_W-1:0]     r_type, n_type;
    logic [BYTE_W-1:0]     r_op, n_op;
    logic [BYTE_W-1:0]     r_asm, n_asm;
    logic                  r_hi, n_hi;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_failed, n_failed;

    logic [COUNT_BITS-1:0] w_count_inc;
    logic [REC_CNT_W-1:0]  w_cur_view;
    logic [REC_CNT_W-1:0]  w_inc_view;
    logic [LEN_W-1:0]      w_len;
    logic [PLIM_W-1:0]     w_plim;
    t_result               res;
    logic                  res_v;

    // Saturating record counter increment.
    assign w_count_inc = (&r_count) ? r_count : r_count + COUNT_BITS'(1);

    // Reported count saturates at the width of the result field.
    generate
        if (COUNT_BITS > REC_CNT_W) begin : g_wide
            assign w_cur_view = (|r_count[COUNT_BITS-1:REC_CNT_W]) ? '1
                                                                    : r_count[REC_CNT_W-1:0];
            assign w_inc_view = (|w_count_inc[COUNT_BITS-1:REC_CNT_W]) ? '1
                                                                        : w_count_inc[REC_CNT_W-1:0];
        end else if (COUNT_BITS == REC_CNT_W) begin : g_equal
            assign w_cur_view = r_count;
            assign w_inc_view = w_count_inc;
        end else begin : g_narrow
            assign w_cur_view = {{(REC_CNT_W-COUNT_BITS){1'b0}}, r_count};
            assign w_inc_view = {{(REC_CNT_W-COUNT_BITS){1'b0}}, w_count_inc};
        end
    endgenerate

    // A two-byte length is assembled from the previous byte and this one.
    assign w_len  = {r_asm, i_data_byte};
    assign w_plim = (i_payload_limit > PLIM_CEIL) ? PLIM_CEIL : i_payload_limit;

    // Parse step for the item on the input.
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_type   = r_type;
        n_op     = r_op;
        n_asm    = r_asm;
        n_hi     = r_hi;
        n_count  = r_count;
        n_failed = r_failed;

        res       = '0;
        res.rtype = r_type;
        res.op    = r_op;
        res.count = w_cur_view;
        res_v     = 1'b0;

        if (i_kind) begin
            // End of stream: report and restart.
            res.ev   = EV_END;
            res.flag = r_failed || (r_phase != PH_HEADER) || (r_cnt != '0);
            res_v    = 1'b1;
            n_phase  = PH_HEADER;
            n_cnt    = '0;
            n_type   = '0;
            n_op     = '0;
            n_asm    = '0;
            n_hi     = 1'b0;
            n_count  = '0;
            n_failed = 1'b0;
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_cnt == HDR_TYPE_POS) begin
                        n_type = i_data_byte;
                    end
                    if (r_cnt == HDR_OP_POS) begin
                        n_op = i_data_byte;
                    end
                    if (r_cnt == HDR_LEN_POS || r_cnt == HDR_LAST_POS) begin
                        n_asm = i_data_byte;
                    end
                    if (r_cnt < HDR_LAST_POS) begin
                        n_cnt = r_cnt + LEN_W'(1);
                    end else if (w_len >= i_key_limit) begin
                        res.ev   = EV_ERROR;
                        res.flag = ERR_KEY_LONG;
                        res_v    = 1'b1;
                        n_failed = 1'b1;
                        n_phase  = PH_ERROR;
                        n_cnt    = '0;
                    end else begin
                        res.ev  = EV_HEADER;
                        res.len = w_len;
                        res_v   = 1'b1;
                        n_cnt   = w_len;
                        n_phase = (w_len == '0) ? PH_PLEN : PH_KEY;
                        n_asm   = '0;
                    end
                end
                PH_KEY: begin
                    res.ev   = EV_KEY;
                    res.data = i_data_byte;
                    res_v    = 1'b1;
                    n_cnt    = r_cnt - LEN_W'(1);
                    if (n_cnt == '0) begin
                        n_phase = PH_PLEN;
                    end
                end
                PH_PLEN: begin
                    n_asm = i_data_byte;
                    // Any set bit in the two upper length bytes exceeds every limit.
                    if (r_cnt == '0) begin
                        n_hi = (i_data_byte != '0);
                    end else if (r_cnt == PLEN_HI1_POS) begin
                        n_hi = r_hi || (i_data_byte != '0);
                    end
                    if (r_cnt < PLEN_LAST_POS) begin
                        n_cnt = r_cnt + LEN_W'(1);
                    end else if (r_hi || ({1'b0, w_len} >= w_plim)) begin
                        res.ev   = EV_ERROR;
                        res.flag = ERR_PAYLOAD_LONG;
                        res_v    = 1'b1;
                        n_failed = 1'b1;
                        n_phase  = PH_ERROR;
                        n_cnt    = '0;
                    end else begin
                        res.ev  = EV_PLEN;
                        res.len = w_len;
                        res_v   = 1'b1;
                        n_cnt   = w_len;
                        n_asm   = '0;
                        if (w_len == '0) begin
                            n_count   = w_count_inc;
                            res.count = w_inc_view;
                            res.done  = 1'b1;
                            n_phase   = PH_HEADER;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    res.ev   = EV_PAYLOAD;
                    res.data = i_data_byte;
                    res_v    = 1'b1;
                    n_cnt    = r_cnt - LEN_W'(1);
                    if (n_cnt == '0) begin
                        n_count   = w_count_inc;
                        res.count = w_inc_view;
                        res.done  = 1'b1;
                        n_phase   = PH_HEADER;
                    end
                end
                PH_ERROR: begin
                    // Bytes are dropped until end of stream.
                    res_v = 1'b0;
                end
                default: begin
                    res_v = 1'b0;
                end
            endcase
        end
    end

    // Parse state advances only on an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_cnt    <= '0;
            r_type   <= '0;
            r_op     <= '0;
            r_asm    <= '0;
            r_hi     <= 1'b0;
            r_count  <= '0;
            r_failed <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_type   <= n_type;
            r_op     <= n_op;
            r_asm    <= n_asm;
            r_hi     <= n_hi;
            r_count  <= n_count;
            r_failed <= n_failed;
        end
    end

    assign o_res       = res;
    assign o_res_valid = i_accept && res_v;

endmodule

`default_nettype wire

// ===== hdl/lrd_queue.sv =====
// ============================================================================
// lrd_queue: result queue between parser and output stage
// A small first-in first-out buffer of compact result records that lets the
// parser and the output side stall independently.
// ============================================================================
`default_nettype none

module lrd_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire lrd_pkg::t_result i_wr_data,
    input  wire logic             i_rd,
    output lrd_pkg::t_result      o_rd_data,
    output logic                  o_full,
    output logic                  o_empty
);
    import lrd_pkg::*;

    t_result               r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_fill;
    logic                  w_wr;
    logic                  w_rd;

    assign o_full  = (r_fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    // Storage slots.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_fill <= r_fill + (QUEUE_AW+1)'(1);
            end else if (w_rd && !w_wr) begin
                r_fill <= r_fill - (QUEUE_AW+1)'(1);
            end
        end
    end

    assign o_rd_data = r_slot[r_rd_ptr];

endmodule

`default_nettype wire

// ===== hdl/lrd_back.sv =====
// ============================================================================
// lrd_back: result output stage
// Pulls records from the result queue into an output register and expands
// each into the result fields, clearing those that do not apply to its event.
// ============================================================================
`default_nettype none

module lrd_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lrd_pkg::t_result              i_q_data,
    input  wire logic                          i_q_empty,
    output logic                               o_q_rd,
    input  wire logic                          i_pop,
    output logic                               o_empty,
    output logic [lrd_pkg::EVENT_W-1:0]        o_event_res,
    output logic [lrd_pkg::BYTE_W-1:0]         o_record_type,
    output logic [lrd_pkg::BYTE_W-1:0]         o_operation,
    output logic [lrd_pkg::LEN_W-1:0]          o_key_length,
    output logic [lrd_pkg::LEN_W-1:0]          o_payload_length,
    output logic [lrd_pkg::BYTE_W-1:0]         o_data_out,
    output logic                               o_record_done,
    output logic                               o_error_code,
    output logic                               o_end_status,
    output logic [lrd_pkg::REC_CNT_W-1:0]      o_record_count
);
    import lrd_pkg::*;

    t_result r_out;
    logic    r_valid;
    logic    w_load;

    // Refill the output register when it is free or being taken this cycle.
    assign w_load = !i_q_empty && (!r_valid || i_pop);
    assign o_q_rd = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= i_q_data;
        end
    end

    // Field expansion by event.
    always_comb begin
        o_event_res      = r_out.ev;
        o_record_type    = r_out.rtype;
        o_operation      = r_out.op;
        o_record_count   = r_out.count;
        o_record_done    = r_out.done;
        o_key_length     = (r_out.ev == EV_HEADER) ? r_out.len : '0;
        o_payload_length = (r_out.ev == EV_PLEN) ? r_out.len : '0;
        o_data_out       = (r_out.ev == EV_KEY || r_out.ev == EV_PAYLOAD) ? r_out.data : '0;
        o_error_code     = (r_out.ev == EV_ERROR) ? r_out.flag : 1'b0;
        o_end_status     = (r_out.ev == EV_END) ? r_out.flag : 1'b0;
    end

    assign o_empty = !r_valid;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the log record deframer
// Feeds byte streams of log records through the push/full input queue, keeps
// a cycle-free parser model of its own that predicts every result, and
// checks each popped result field by field. Directed cases cover empty,
// minimal, truncated and oversized records and the limit extremes; random
// streams with bursty input and stalling output cover the rest.
// ----------------------------------------------------------------------------
module tb_top;

    import lrd_pkg::*;

    // Input item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Cycles allowed for items that give no result to leave the pipeline.
    localparam int IDLE_GAP       = 8;
    // Longest run of cycles without any transaction before giving up.
    localparam int WATCHDOG_LIMIT = 4000;
    // Length of the long receiver hold-off in the back-pressure test.
    localparam int LONG_HOLD      = 300;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    // One expected result of the parser.
    typedef struct packed {
        logic [EVENT_W-1:0]   ev;
        logic [BYTE_W-1:0]    rtype;
        logic [BYTE_W-1:0]    op;
        logic [LEN_W-1:0]     klen;
        logic [LEN_W-1:0]     plen;
        logic [BYTE_W-1:0]    data;
        logic                 done;
        logic                 err;
        logic                 status;
        logic [REC_CNT_W-1:0] count;
    } t_parse_result;

    // Block ports.
    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    logic                  i_kind      = 1'b0;
    logic [BYTE_W-1:0]     i_data_byte = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    logic [EVENT_W-1:0]    o_event_res;
    logic [BYTE_W-1:0]     o_record_type;
    logic [BYTE_W-1:0]     o_operation;
    logic [LEN_W-1:0]      o_key_length;
    logic [LEN_W-1:0]      o_payload_length;
    logic [BYTE_W-1:0]     o_data_out;
    logic                  o_record_done;
    logic                  o_error_code;
    logic                  o_end_status;
    logic [REC_CNT_W-1:0]  o_record_count;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [PLIM_W-1:0]     i_cfg_data  = '0;

    // Parser model state and its copy of the limit registers.
    t_phase                phase_q;
    logic [LEN_W-1:0]      count_q;
    logic [BYTE_W-1:0]     type_q;
    logic [BYTE_W-1:0]     op_q;
    logic [31:0]           length_q;
    logic [REC_CNT_W-1:0]  records_q;
    logic                  failed_q;
    logic [LEN_W-1:0]      key_lim;
    logic [PLIM_W-1:0]     pay_lim;

    t_parse_result         expected_events[$];

    // Stimulus shaping and run statistics.
    t_rx_mode              rx_mode       = RX_ALWAYS;
    logic [15:0]           rx_pattern    = 16'hFFFF;
    int                    rx_step       = 0;
    int                    hold_request  = 0;
    int                    hold_left     = 0;
    bit                    tx_gaps       = 1'b0;
    int                    burst_left    = 0;
    int                    items_sent    = 0;
    int                    input_stalls  = 0;
    int                    results_seen  = 0;
    int                    records_seen  = 0;
    int                    faults_seen   = 0;
    int                    ends_seen     = 0;
    int                    mismatch_count = 0;
    int                    idle_cycles   = 0;

    log_record_deframer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_kind           (i_kind),
        .i_data_byte      (i_data_byte),
        .empty            (empty),
        .pop              (pop),
        .o_event_res      (o_event_res),
        .o_record_type    (o_record_type),
        .o_operation      (o_operation),
        .o_key_length     (o_key_length),
        .o_payload_length (o_payload_length),
        .o_data_out       (o_data_out),
        .o_record_done    (o_record_done),
        .o_error_code     (o_error_code),
        .o_end_status     (o_end_status),
        .o_record_count   (o_record_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Restart of the stream: everything but the limits is cleared.
    function automatic void clear_parser();
        phase_q   = PH_HEADER;
        count_q   = '0;
        type_q    = '0;
        op_q      = '0;
        length_q  = '0;
        records_q = '0;
        failed_q  = 1'b0;
    endfunction

    // Every result carries the held header bytes and the record count.
    function automatic t_parse_result base_event(input logic [EVENT_W-1:0] ev);
        t_parse_result r;
        r       = '0;
        r.ev    = ev;
        r.rtype = type_q;
        r.op    = op_q;
        r.count = records_q;
        return r;
    endfunction

    function automatic void count_record();
        if (records_q != '1)
            records_q++;
    endfunction

    // An oversized length stops parsing until the end of the stream.
    function automatic void raise_fault(input logic code);
        t_parse_result r;
        failed_q = 1'b1;
        phase_q  = PH_ERROR;
        count_q  = '0;
        r        = base_event(EV_ERROR);
        r.err    = code;
        expected_events.push_back(r);
    endfunction

    // Advances the model by one accepted item and queues any result.
    function automatic void parse_item(input logic is_end, input logic [BYTE_W-1:0] b);
        t_parse_result     r;
        logic [PLIM_W-1:0] plim_eff;
        if (is_end) begin
            r        = base_event(EV_END);
            r.status = failed_q || (phase_q != PH_HEADER) || (count_q != '0);
            expected_events.push_back(r);
            clear_parser();
            return;
        end
        case (phase_q)
            PH_HEADER: begin
                if (count_q == HDR_TYPE_POS)
                    type_q = b;
                else if (count_q == HDR_OP_POS)
                    op_q = b;
                else if (count_q == HDR_LEN_POS)
                    length_q = {24'd0, b};
                else if (count_q == HDR_LAST_POS)
                    length_q = {16'd0, length_q[7:0], b};
                if (count_q < HDR_LAST_POS) begin
                    count_q++;
                    return;
                end
                if (length_q >= {16'd0, key_lim}) begin
                    raise_fault(ERR_KEY_LONG);
                    return;
                end
                r        = base_event(EV_HEADER);
                r.klen   = length_q[15:0];
                count_q  = length_q[15:0];
                phase_q  = (count_q == '0) ? PH_PLEN : PH_KEY;
                length_q = '0;
                expected_events.push_back(r);
            end
            PH_KEY: begin
                r       = base_event(EV_KEY);
                r.data  = b;
                count_q = count_q - 1'b1;
                if (count_q == '0)
                    phase_q = PH_PLEN;
                expected_events.push_back(r);
            end
            PH_PLEN: begin
                length_q = (count_q == '0) ? {24'd0, b} : {length_q[23:0], b};
                if (count_q < PLEN_LAST_POS) begin
                    count_q++;
                    return;
                end
                plim_eff = (pay_lim > PLIM_CEIL) ? PLIM_CEIL : pay_lim;
                if (length_q >= {15'd0, plim_eff}) begin
                    raise_fault(ERR_PAYLOAD_LONG);
                    return;
                end
                count_q = length_q[15:0];
                if (count_q == '0) begin
                    count_record();
                    phase_q = PH_HEADER;
                end else begin
                    phase_q = PH_PAYLOAD;
                end
                r        = base_event(EV_PLEN);
                r.plen   = length_q[15:0];
                r.done   = (count_q == '0);
                length_q = '0;
                expected_events.push_back(r);
            end
            PH_PAYLOAD: begin
                count_q = count_q - 1'b1;
                if (count_q == '0) begin
                    count_record();
                    phase_q = PH_HEADER;
                end
                r      = base_event(EV_PAYLOAD);
                r.data = b;
                r.done = (count_q == '0);
                expected_events.push_back(r);
            end
            default: begin
                // Bytes after an error are dropped without a result.
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("result %0d %s is %0h, expected %0h",
                             results_seen, name, got, want));
    endtask

    // Model update and result comparison, both on accepted transactions.
    always @(posedge i_clk) begin : check_results
        t_parse_result want;
        if (!i_rst_n) begin
            clear_parser();
            key_lim = KEY_LIMIT_RST;
            pay_lim = PAYLOAD_LIMIT_RST;
        end else begin
            if (pop && !empty) begin
                if (expected_events.size() == 0) begin
                    report($sformatf("result with event %0d arrived, none expected",
                                     o_event_res));
                end else begin
                    want = expected_events.pop_front();
                    check_field("event", o_event_res, want.ev);
                    check_field("record type", o_record_type, want.rtype);
                    check_field("operation", o_operation, want.op);
                    check_field("key length", o_key_length, want.klen);
                    check_field("payload length", o_payload_length, want.plen);
                    check_field("data", o_data_out, want.data);
                    check_field("record done", o_record_done, want.done);
                    check_field("error code", o_error_code, want.err);
                    check_field("end status", o_end_status, want.status);
                    check_field("record count", o_record_count, want.count);
                    if (want.done)
                        records_seen++;
                    if (want.ev == EV_ERROR)
                        faults_seen++;
                    if (want.ev == EV_END)
                        ends_seen++;
                end
                results_seen++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_KEY_LIMIT)
                    key_lim = i_cfg_data[LEN_W-1:0];
                else
                    pay_lim = i_cfg_data;
            end
            if (push && !full)
                parse_item(i_kind, i_data_byte);
        end
    end

    // Ends the run when no transaction of any kind has happened for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] Watchdog: no transaction for %0d cycles", $time, idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, plus a long hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            case (rx_mode)
                RX_RANDOM:  pop <= ($urandom_range(0, 9) < 6);
                RX_PATTERN: pop <= rx_pattern[rx_step % 16];
                default:    pop <= 1'b1;
            endcase
            rx_step++;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one item and returns at the edge where it is accepted.
    task automatic send_item(input logic kind, input logic [BYTE_W-1:0] b);
        int gap;
        if (tx_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        push        <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= b;
        @(posedge i_clk);
        while (full) begin
            input_stalls++;
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // Sends one record, or only its first cut bytes when cut is not negative.
    task automatic send_record(input logic [BYTE_W-1:0] rtype, input logic [BYTE_W-1:0] op,
                               input logic [31:0] klen, input logic [31:0] plen,
                               input int cut);
        logic [BYTE_W-1:0] rec[$];
        int                i;
        int                n;
        rec = {};
        repeat (8) rec.push_back(rand_byte());
        rec.push_back(rtype);
        rec.push_back(op);
        rec.push_back(klen[15:8]);
        rec.push_back(klen[7:0]);
        for (i = 0; i < klen[15:0] && (cut < 0 || rec.size() < cut); i++)
            rec.push_back(rand_byte());
        rec.push_back(plen[31:24]);
        rec.push_back(plen[23:16]);
        rec.push_back(plen[15:8]);
        rec.push_back(plen[7:0]);
        for (i = 0; i < plen && (cut < 0 || rec.size() < cut); i++)
            rec.push_back(rand_byte());
        n = (cut >= 0 && cut < rec.size()) ? cut : rec.size();
        for (i = 0; i < n; i++)
            send_item(KIND_BYTE, rec[i]);
    endtask

    // Stops offering, then waits until every expected result has come and
    // the last items without a result have left the pipeline.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_events.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    // Writes both limit registers while the block is idle.
    task automatic set_limits(input logic [PLIM_W-1:0] klim, input logic [PLIM_W-1:0] plim);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_KEY_LIMIT;
        i_cfg_data  <= klim;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_PAYLOAD_LIMIT;
        i_cfg_data  <= plim;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Minimal and ordinary records under the reset limits.
    task automatic test_basic_records();
        rx_mode = RX_ALWAYS;
        tx_gaps = 1'b0;
        send_item(KIND_END, 8'h00);
        send_record(8'h00, 8'hFF, 0, 0, -1);
        send_record(8'hFF, 8'h00, 2, 3, -1);
        send_record(8'h5A, 8'hA5, 1, 1, -1);
        send_item(KIND_END, 8'hFF);
    endtask

    // Oversized key and payload lengths, the first two followed by ignored bytes.
    task automatic test_length_errors();
        rx_mode = RX_RANDOM;
        tx_gaps = 1'b1;
        send_record(8'h11, 8'h22, 256, 0, 12);
        repeat (3) send_item(KIND_BYTE, rand_byte());
        send_item(KIND_END, rand_byte());
        send_record(8'h33, 8'h44, 1, 4096, 17);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_END, rand_byte());
        send_record(8'h55, 8'h66, 0, 32'hFFFF_FFFF, 16);
        send_item(KIND_END, rand_byte());
        send_record(8'h77, 8'h88, 0, 32'h0001_0000, 16);
        send_item(KIND_END, rand_byte());
    endtask

    // End of stream at every stage of a record.
    task automatic test_truncation();
        int cut_at[4];
        cut_at = '{7, 14, 17, 22};
        rx_mode = RX_RANDOM;
        tx_gaps = 1'b1;
        foreach (cut_at[k]) begin
            send_record(rand_byte(), rand_byte(), 3, 5, cut_at[k]);
            send_item(KIND_END, rand_byte());
        end
        send_record(rand_byte(), rand_byte(), 0, 0, -1);
        send_item(KIND_END, rand_byte());
        send_item(KIND_END, rand_byte());
    endtask

    // Zero, one and largest limits, including a payload limit above the ceiling.
    task automatic test_limit_extremes();
        rx_mode = RX_ALWAYS;
        tx_gaps = 1'b0;
        set_limits(17'd0, 17'd4096);
        send_record(rand_byte(), rand_byte(), 0, 0, 12);
        send_item(KIND_END, rand_byte());

        // A key limit written with bit 16 set keeps only its low 16 bits.
        set_limits(17'h1FFFF, 17'd0);
        send_record(rand_byte(), rand_byte(), 0, 0, 16);
        send_item(KIND_END, rand_byte());
        send_record(rand_byte(), rand_byte(), 65535, 0, 12);
        send_item(KIND_END, rand_byte());

        set_limits(17'd1, 17'd1);
        send_record(rand_byte(), rand_byte(), 0, 0, -1);
        send_record(rand_byte(), rand_byte(), 1, 0, 12);
        send_item(KIND_END, rand_byte());
        send_record(rand_byte(), rand_byte(), 0, 1, 16);
        send_item(KIND_END, rand_byte());

        set_limits(17'd65535, 17'h1FFFF);
        send_record(rand_byte(), rand_byte(), 65534, 0, 20);
        send_item(KIND_END, rand_byte());
        send_record(rand_byte(), rand_byte(), 0, 65535, 30);
        send_item(KIND_END, rand_byte());
        send_record(rand_byte(), rand_byte(), 0, 65536, 16);
        send_item(KIND_END, rand_byte());

        set_limits(17'd65535, 17'd65536);
        send_record(rand_byte(), rand_byte(), 0, 65535, 20);
        send_item(KIND_END, rand_byte());
        send_record(rand_byte(), rand_byte(), 0, 65536, 16);
        send_item(KIND_END, rand_byte());
    endtask

    // The receiver holds off for a long stretch while records keep coming,
    // so the result queue fills and the input stalls.
    task automatic test_backpressure();
        set_limits(17'd256, 17'd4096);
        rx_mode = RX_ALWAYS;
        tx_gaps = 1'b0;
        hold_request = LONG_HOLD;
        repeat (4) send_record(rand_byte(), rand_byte(), 3, 40, -1);
        send_item(KIND_END, rand_byte());
    endtask

    // Mostly well-formed records with random content, mixed with stream ends,
    // truncated and oversized records and loose noise.
    task automatic run_random_stream(input int target, input logic [31:0] klim,
                                     input logic [31:0] plim_eff);
        int          start;
        int          pick;
        logic [31:0] klen;
        logic [31:0] plen;
        start = items_sent;
        while (items_sent - start < target) begin
            pick = $urandom_range(0, 99);
            klen = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
            plen = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
            if (pick < 75) begin
                send_record(rand_byte(), rand_byte(), klen, plen, -1);
            end else if (pick < 83) begin
                send_item(KIND_END, rand_byte());
            end else if (pick < 89) begin
                send_record(rand_byte(), rand_byte(), klen, plen,
                            $urandom_range(1, 15 + klen + plen));
                send_item(KIND_END, rand_byte());
            end else if (pick < 94) begin
                if ($urandom_range(0, 1)) begin
                    klen = klim + $urandom_range(0, 2);
                    if (klen > 65535)
                        klen = 65535;
                    send_record(rand_byte(), rand_byte(), klen, 0, 12);
                end else begin
                    send_record(rand_byte(), rand_byte(), 0,
                                plim_eff + $urandom_range(0, 2), 16);
                end
                repeat ($urandom_range(0, 6)) send_item(KIND_BYTE, rand_byte());
                send_item(KIND_END, rand_byte());
            end else begin
                repeat ($urandom_range(1, 8)) send_item(KIND_BYTE, rand_byte());
                send_item(KIND_END, rand_byte());
            end
        end
        send_item(KIND_END, rand_byte());
    endtask

    // Three random phases under different limits and idling patterns.
    task automatic test_random_streams();
        set_limits(17'd256, 17'd4096);
        rx_mode = RX_RANDOM;
        tx_gaps = 1'b1;
        run_random_stream(420, 256, 4096);

        set_limits(17'd6, 17'd12);
        rx_pattern = 16'($urandom_range(0, 65535)) | 16'h0001;
        rx_mode = RX_PATTERN;
        tx_gaps = 1'b0;
        run_random_stream(420, 6, 12);

        set_limits(17'd65535, 17'h1FFFF);
        rx_mode = RX_ALWAYS;
        tx_gaps = 1'b1;
        run_random_stream(420, 65535, 65536);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : test_sequence
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_records();
        test_length_errors();
        test_truncation();
        test_limit_extremes();
        test_backpressure();
        test_random_streams();
        wait_idle();

        $display("Covered %0d input items (%0d cycles stalled on full) and %0d results.",
                 items_sent, input_stalls, results_seen);
        $display("Results held %0d completed records, %0d length errors, %0d stream ends.",
                 records_seen, faults_seen, ends_seen);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== log_record_deframer.f =====
hdl/lrd_pkg.sv
hdl/lrd_front.sv
hdl/lrd_queue.sv
hdl/lrd_back.sv
hdl/log_record_deframer.sv
tb/tb_top.sv
